/* rtl/core/gpf_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// gpf_pkg
// Shared types and constants for the partition finder: sequencer states,
// divider job kinds, search phases and result status codes.
// -----------------------------------------------------------------------------
package gpf_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 31;
    localparam int STATUS_WIDTH        = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PT_BEGIN,
        S_DIV,
        S_DIV_EVAL,
        S_PASS,
        S_FAIL,
        S_DONE
    } state_t;

    // What the divider is currently working on.
    typedef enum logic [1:0] {
        K_BY3,
        K_BY_D,
        K_BY_D2
    } div_kind_t;

    typedef enum logic [2:0] {
        PHASE_IDLE       = 3'd0,
        PHASE_CANDIDATE  = 3'd1,
        PHASE_COMPLEMENT = 3'd2
    } phase_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_FOUND   = 2'd0,
        ST_INVALID = 2'd1,
        ST_NONE    = 2'd2
    } status_t;

endpackage
`default_nettype wire

/* rtl/core/goldbach_partition_finder.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// goldbach_partition_finder
// Finds the smallest prime p with target - p also prime, by trial division
// through a single shared bit-serial divider.
// -----------------------------------------------------------------------------
// One word in gives one word out. Every primality test runs through one
// restoring divider that produces one quotient bit per clock, and each trial
// division is followed by an evaluation step in S_DIV_EVAL. A test of a
// prime v runs the division by three, two divisions for each 6k-1, 6k+1 pair
// up to sqrt(v) and one last division that ends the loop, plus a setup state
// (S_PT_BEGIN) and a verdict state (S_PASS or S_FAIL). A composite stops at
// its first divisor. The search repeats the test for each candidate p up to
// the first pair found. The input is ready only while the sequencer is idle;
// a finished result waits in the output register and the next word may be
// taken meanwhile. Invalid targets (odd or below four) go from idle straight
// to S_DONE, which loads the result word into the output register once that
// register is free.
// -----------------------------------------------------------------------------
module goldbach_partition_finder
    import gpf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: target_value, zero padding
    input  wire logic [(VALUE_WIDTH + 7) / 8 * 8 - 1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata: first_prime, second_prime, zero padding
    output logic [(2 * VALUE_WIDTH + 7) / 8 * 8 - 1:0]  m_axis_tdata,
    // tuser: status
    output logic [STATUS_WIDTH-1:0]      m_axis_tuser
);

    localparam int OUT_BYTES = (2 * VALUE_WIDTH + 7) / 8;
    localparam int OUT_PAD   = OUT_BYTES * 8 - 2 * VALUE_WIDTH;
    localparam int CNT_W     = $clog2(VALUE_WIDTH);
    localparam int W         = VALUE_WIDTH;

    localparam logic [W-1:0] ONE   = W'(1);
    localparam logic [W-1:0] TWO   = W'(2);
    localparam logic [W-1:0] THREE = W'(3);
    localparam logic [W-1:0] FOUR  = W'(4);
    localparam logic [W-1:0] FIVE  = W'(5);

    state_t                  state_reg, state_next;
    div_kind_t               kind_reg, kind_next;
    phase_t                  phase_reg, phase_next;
    logic [W-1:0]            target_reg, target_next;
    logic [W-1:0]            cand_reg, cand_next;
    logic [W-1:0]            trial_reg, trial_next;
    logic [W-1:0]            test_reg, test_next;
    logic [W-1:0]            rem_reg, rem_next;
    logic [W-1:0]            quo_reg, quo_next;
    logic [W-1:0]            den_reg, den_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [W-1:0]            res_first_reg, res_first_next;
    logic [W-1:0]            res_second_reg, res_second_next;
    status_t                 res_status_reg, res_status_next;
    logic [W-1:0]            out_first_reg, out_first_next;
    logic [W-1:0]            out_second_reg, out_second_next;
    status_t                 out_status_reg, out_status_next;
    logic                    out_valid_reg, out_valid_next;

    logic [W-1:0]            in_value;
    logic                    in_accept;
    logic                    in_invalid;
    logic [W:0]              div_trial;
    logic                    div_fits;
    logic                    rem_zero;
    logic                    pt_pass_early;
    logic                    pt_fail_early;
    logic                    eval_pass;
    logic                    eval_fail;
    logic [W-1:0]            cand_inc;
    logic                    cand_exhausted;
    logic                    out_load;

    assign in_value   = s_axis_tdata[W-1:0];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_invalid = (in_value < FOUR) || in_value[0];

    // Restoring division step: bring the next dividend bit into the remainder.
    assign div_trial = {rem_reg, quo_reg[W-1]};
    assign div_fits  = (div_trial >= {1'b0, den_reg});
    assign rem_zero  = (rem_reg == '0);

    assign pt_pass_early = (test_reg >= TWO) && (test_reg < FOUR);
    assign pt_fail_early = (test_reg < TWO) || !test_reg[0];

    // The trial loop ends once the divisor exceeds the quotient value / divisor.
    always_comb
    begin
        eval_pass = 1'b0;
        eval_fail = 1'b0;
        case (kind_reg)
            K_BY3:
            begin
                eval_fail = rem_zero;
            end
            K_BY_D:
            begin
                eval_pass = (den_reg > quo_reg);
                eval_fail = !eval_pass && rem_zero;
            end
            K_BY_D2:
            begin
                eval_fail = rem_zero;
            end
            default:
            begin
                eval_fail = 1'b0;
            end
        endcase
    end

    assign cand_inc       = cand_reg + ONE;
    assign cand_exhausted = (cand_inc > (target_reg >> 1));
    assign out_load       = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_invalid ? S_DONE : S_PT_BEGIN;
                end
            end
            S_PT_BEGIN:
            begin
                if (pt_pass_early)
                begin
                    state_next = S_PASS;
                end
                else if (pt_fail_early)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV_EVAL;
                end
            end
            S_DIV_EVAL:
            begin
                if (eval_pass)
                begin
                    state_next = S_PASS;
                end
                else if (eval_fail)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_PASS:
            begin
                state_next = (phase_reg == PHASE_COMPLEMENT) ? S_DONE : S_PT_BEGIN;
            end
            S_FAIL:
            begin
                state_next = cand_exhausted ? S_DONE : S_PT_BEGIN;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        kind_next       = kind_reg;
        phase_next      = phase_reg;
        target_next     = target_reg;
        cand_next       = cand_reg;
        trial_next      = trial_reg;
        test_next       = test_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        den_next        = den_reg;
        cnt_next        = cnt_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        res_status_next = res_status_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    target_next     = in_value;
                    res_first_next  = '0;
                    res_second_next = '0;
                    if (in_invalid)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else
                    begin
                        res_status_next = ST_NONE;
                        cand_next       = TWO;
                        test_next       = TWO;
                        phase_next      = PHASE_CANDIDATE;
                    end
                end
            end
            S_PT_BEGIN:
            begin
                // Start the division by three.
                kind_next = K_BY3;
                rem_next  = '0;
                quo_next  = test_reg;
                den_next  = THREE;
                cnt_next  = CNT_W'(W - 1);
            end
            S_DIV:
            begin
                if (div_fits)
                begin
                    rem_next = W'(div_trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = div_trial[W-1:0];
                end
                quo_next = {quo_reg[W-2:0], div_fits};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            S_DIV_EVAL:
            begin
                rem_next = '0;
                quo_next = test_reg;
                cnt_next = CNT_W'(W - 1);
                case (kind_reg)
                    K_BY3:
                    begin
                        kind_next  = K_BY_D;
                        den_next   = FIVE;
                        trial_next = FIVE;
                    end
                    K_BY_D:
                    begin
                        kind_next = K_BY_D2;
                        den_next  = den_reg + TWO;
                    end
                    K_BY_D2:
                    begin
                        kind_next  = K_BY_D;
                        den_next   = den_reg + FOUR;
                        trial_next = den_reg + FOUR;
                    end
                    default:
                    begin
                        kind_next = K_BY3;
                    end
                endcase
            end
            S_PASS:
            begin
                if (phase_reg == PHASE_COMPLEMENT)
                begin
                    res_first_next  = cand_reg;
                    res_second_next = test_reg;
                    res_status_next = ST_FOUND;
                    phase_next      = PHASE_IDLE;
                end
                else
                begin
                    test_next  = target_reg - cand_reg;
                    phase_next = PHASE_COMPLEMENT;
                end
            end
            S_FAIL:
            begin
                if (cand_exhausted)
                begin
                    phase_next = PHASE_IDLE;
                end
                else
                begin
                    cand_next  = cand_inc;
                    test_next  = cand_inc;
                    phase_next = PHASE_CANDIDATE;
                end
            end
            S_DONE:
            begin
                phase_next = PHASE_IDLE;
                if (out_load)
                begin
                    out_first_next  = res_first_reg;
                    out_second_next = res_second_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PHASE_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_second_reg, out_first_reg};
    assign m_axis_tuser  = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PHASE_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            cand_reg      <= '0;
            trial_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            cand_reg      <= cand_next;
            trial_reg     <= trial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        test_reg       <= test_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        den_reg        <= den_next;
        cnt_reg        <= cnt_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        res_status_reg <= res_status_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_status_reg <= out_status_next;
    end

endmodule
`default_nettype wire
